>>> rtl/arp_tbl_pkg.sv
// Shared types and constants for the ARP address table.
package arp_tbl_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned IP_W          = 32;
  localparam int unsigned MAC_W         = 48;
  localparam int unsigned OUT_IDX_W     = 4;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [MAC_W-1:0]     mac_out;
    logic [OUT_IDX_W-1:0] entry_index;
  } out_item_t;

  // Priority chain passed from each cell to its right-hand neighbour.
  typedef struct packed {
    logic             hit_seen;
    logic             free_seen;
    logic [MAC_W-1:0] hit_mac;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
  } chain_t;

endpackage

>>> rtl/arp_tbl_cell.sv
// One table entry: valid bit, address and MAC, with its link in the priority chain.
module arp_tbl_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  arp_tbl_pkg::in_item_t         req_i,
  input  logic [arp_tbl_pkg::IDX_W-1:0] cell_idx_i,
  input  logic                          any_hit_i,
  input  arp_tbl_pkg::chain_t           chain_i,
  output arp_tbl_pkg::chain_t           chain_o,
  output logic                          valid_o
);
  import arp_tbl_pkg::*;

  logic             valid_q, valid_d;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;
  logic             match, sel_hit, sel_free;
  logic             wr_mac, wr_new;

  assign match    = valid_q && (ip_q == req_i.ip_addr);
  assign sel_hit  = match && !chain_i.hit_seen;
  assign sel_free = !valid_q && !chain_i.free_seen;

  always_comb begin
    chain_o.hit_seen  = chain_i.hit_seen | match;
    chain_o.free_seen = chain_i.free_seen | !valid_q;
    chain_o.hit_mac   = sel_hit ? mac_q : chain_i.hit_mac;
    chain_o.hit_idx   = sel_hit ? cell_idx_i : chain_i.hit_idx;
    chain_o.free_idx  = sel_free ? cell_idx_i : chain_i.free_idx;
  end

  // Update a matching entry first; claim a free one only if nothing matched.
  assign wr_mac = en_i && (req_i.opcode == OP_INSERT) && (sel_hit || (!any_hit_i && sel_free));
  assign wr_new = en_i && (req_i.opcode == OP_INSERT) && !any_hit_i && sel_free;

  always_comb begin
    valid_d = valid_q;
    if (en_i) begin
      case (req_i.opcode)
        OP_CLEAR:  valid_d = 1'b0;
        OP_INSERT: if (wr_new) valid_d = 1'b1;
        default:   valid_d = valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_new) begin
      ip_q <= req_i.ip_addr;
    end
    if (wr_mac) begin
      mac_q <= req_i.mac_addr;
    end
  end

  assign valid_o = valid_q;

endmodule

>>> rtl/arp_address_table.sv
// Top level of the ARP address table: request register, cell row and result register.
// Flow: an accepted item waits in the request register until the result register can take
//   its result; the result is then registered there and held until it is taken.
// Flow control: a new item is taken only once the held item has executed; the address compare
//   and the priority ripple along the cell row both happen combinationally in its execute cycle.
// Reset: asynchronous, clears every valid bit, the busy flag and the output valid;
//   no clearing pass, so items are taken as soon as reset is released.
module arp_address_table (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  arp_tbl_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output arp_tbl_pkg::out_item_t out_data_o
);
  import arp_tbl_pkg::*;

  // Request register: holds the accepted item until it has executed.
  logic      busy_q, busy_d;
  in_item_t  req_q;

  // Result register: lets the next item in while a result waits.
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  logic      accept, exec;

  // Chain links: chain[0] feeds cell 0, chain[TABLE_ENTRIES] leaves the last cell.
  chain_t                   chain [0:TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic                     any_hit, any_free;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  // Execute only when the result has somewhere to go.
  assign exec       = busy_q && (!out_valid_q || out_ready_i);

  assign chain[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    arp_tbl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (exec),
      .req_i      (req_q),
      .cell_idx_i (IDX_W'(i)),
      .any_hit_i  (any_hit),
      .chain_i    (chain[i]),
      .chain_o    (chain[i+1]),
      .valid_o    (valid_vec[i])
    );
  end

  // The end of the chain tells every cell whether any entry matched.
  assign any_hit  = chain[TABLE_ENTRIES].hit_seen;
  assign any_free = chain[TABLE_ENTRIES].free_seen;

  // Result formation; entry index is the low bits of the slot number.
  always_comb begin
    logic [IDX_W+OUT_IDX_W-1:0] hit_ext;
    logic [IDX_W+OUT_IDX_W-1:0] free_ext;
    hit_ext  = {{OUT_IDX_W{1'b0}}, chain[TABLE_ENTRIES].hit_idx};
    free_ext = {{OUT_IDX_W{1'b0}}, chain[TABLE_ENTRIES].free_idx};
    out_data_d = '0;
    out_data_d.status = ST_OK;
    case (req_q.opcode)
      OP_LOOKUP: begin
        if (any_hit) begin
          out_data_d.mac_out     = chain[TABLE_ENTRIES].hit_mac;
          out_data_d.entry_index = hit_ext[OUT_IDX_W-1:0];
        end else begin
          out_data_d.status = ST_MISS;
        end
      end
      OP_INSERT: begin
        if (any_hit) begin
          out_data_d.entry_index = hit_ext[OUT_IDX_W-1:0];
        end else if (any_free) begin
          out_data_d.entry_index = free_ext[OUT_IDX_W-1:0];
        end else begin
          out_data_d.status = ST_FULL;
        end
      end
      default: begin
        // clear, and the unused code: plain success, all else zero
        out_data_d.status = ST_OK;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (exec) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if (exec) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // An accepted item is held, awaiting execution, in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted item not held for execution");

  // A clear leaves the whole row empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && (req_q.opcode == OP_CLEAR) |=> (valid_vec == '0))
    else $error("entries still valid after clear");

  // A lookup never changes which entries are valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && (req_q.opcode == OP_LOOKUP) |=> $stable(valid_vec))
    else $error("lookup altered the valid bits");

  // Table full is reported only when every entry was valid, and nothing changes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && (req_q.opcode == OP_INSERT) |=>
      (out_data_q.status != ST_FULL) || ($past(&valid_vec) && $stable(valid_vec)))
    else $error("table full reported with a free entry");

endmodule
